### src/polar_sector_hit_test_macros.svh
// Assertion helpers used by polar_sector_hit_test.sv.
`ifndef POLAR_SECTOR_HIT_TEST_MACROS_SVH
`define POLAR_SECTOR_HIT_TEST_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define PSHT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define PSHT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/psht_pkg.sv
package psht_pkg;

    localparam int CORDIC_STAGES = 16;  // 8..24
    localparam int ANGLE_BITS    = 16;  // 10..24

    localparam int PT_W      = 16;      // point coordinate width
    localparam int RAD_W     = 14;
    localparam int SC_W      = 8;
    localparam int DELTA_W   = 17;      // dx, dy span -49151..49151
    localparam int SQ_W      = 32;      // dx*dx < 2^32
    localparam int RSQ_W     = 2 * RAD_W;
    localparam int FRAC_BITS = 20;      // CORDIC fraction bits
    localparam int CW        = DELTA_W + 3 + FRAC_BITS;  // room for gain and sqrt(2)
    localparam int Z_W       = 32;      // binary angle, 2^32 per turn

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = RAD_W;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_COUNT = 1'd1;

    localparam logic [Z_W-1:0] HALF_TURN = 32'h8000_0000;

    localparam logic [Z_W-1:0] ATAN_TURNS [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

endpackage

### src/polar_sector_hit_test.sv
// Polar sector hit test. Each point (point_x, point_y, view coordinates in
// 1/16 pixel, y down) is checked against a circle of the configured radius
// centred at (radius, radius). Points within or on the circle get an angle
// from an unrolled vectoring CORDIC and are mapped to one of sector_count
// equal sectors, numbered from 1 counter-clockwise from the +x axis; points
// outside, or any point while sector_count is 0, give sector 0. The block
// takes one transaction per clock while s_tready is high and returns one
// result transaction per input transaction in order. A point passes
// CORDIC_STAGES + 5 registers (21 at the default of 16 stages): one stage
// for the offsets, one for the squares and pre-rotation, one per CORDIC
// iteration, then rounding, the sector multiply and the output register.
// A one-entry skid buffer behind the output register keeps the pipeline
// moving while a result waits; the whole pipeline holds only once that
// buffer is full. Configuration is written through cfg_wen / cfg_addr /
// cfg_wdata; the user must write it only while no transaction is in
// flight, the block itself does not enforce this.
`include "polar_sector_hit_test_macros.svh"

module polar_sector_hit_test (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_wen,
    input  logic [psht_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [psht_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input points
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [31:0]                      s_tdata,   // [15:0] point_x, [31:16] point_y
    // results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [15:0]                      m_tdata    // [7:0] sector, [8] inside_res, rest 0
);
    import psht_pkg::*;

    localparam int N = CORDIC_STAGES;

    // ---------------- configuration registers ----------------
    logic [RAD_W-1:0] radius_reg;
    logic [SC_W-1:0]  sc_reg;
    logic [RSQ_W-1:0] rsq_reg;     // radius squared, registered from radius_reg

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= '0;
            sc_reg     <= '0;
        end else if (cfg_wen) begin
            case (cfg_addr)
                CFG_RADIUS:       radius_reg <= cfg_wdata[RAD_W-1:0];
                CFG_SECTOR_COUNT: sc_reg     <= cfg_wdata[SC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        rsq_reg <= radius_reg * radius_reg;
    end

    // ---------------- pipeline enable ----------------
    // Everything advances together; only a full skid buffer stops it.
    logic en;
    logic skid_vld_reg;
    assign en       = !skid_vld_reg;
    assign s_tready = en;

    // ---------------- stage 1: offsets from the centre ----------------
    logic                      s1_vld_reg;
    logic signed [DELTA_W-1:0] dx_reg, dy_reg;
    logic signed [DELTA_W-1:0] px_ext, py_ext, r_ext;

    assign px_ext = {{(DELTA_W-PT_W){s_tdata[PT_W-1]}}, s_tdata[PT_W-1:0]};
    assign py_ext = {{(DELTA_W-PT_W){s_tdata[2*PT_W-1]}}, s_tdata[2*PT_W-1:PT_W]};
    assign r_ext  = {{(DELTA_W-RAD_W){1'b0}}, radius_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg <= px_ext - r_ext;   // x to the right
            dy_reg <= r_ext - py_ext;   // y flipped to point up
        end
    end

    // ---------------- stage 2 (CORDIC index 0): squares, pre-rotation ----------------
    logic                  vld_reg  [0:N];
    logic signed [CW-1:0]  cx_reg   [0:N];
    logic signed [CW-1:0]  cy_reg   [0:N];
    logic [Z_W-1:0]        cz_reg   [0:N];
    logic                  zero_reg [0:N];   // vector is (0, 0): angle forced to 0
    logic                  ins_reg  [1:N];   // circle test result
    logic [SQ_W-1:0]       sqx_reg, sqy_reg;

    logic signed [CW-1:0]        dx_w, dy_w;
    logic signed [2*DELTA_W-1:0] sqx_full, sqy_full;

    assign dx_w     = {{(CW-DELTA_W-FRAC_BITS){dx_reg[DELTA_W-1]}}, dx_reg, {FRAC_BITS{1'b0}}};
    assign dy_w     = {{(CW-DELTA_W-FRAC_BITS){dy_reg[DELTA_W-1]}}, dy_reg, {FRAC_BITS{1'b0}}};
    assign sqx_full = dx_reg * dx_reg;
    assign sqy_full = dy_reg * dy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_reg     <= sqx_full[SQ_W-1:0];
            sqy_reg     <= sqy_full[SQ_W-1:0];
            zero_reg[0] <= (dx_reg == '0) && (dy_reg == '0);
            // left half plane: rotate by a half turn so x starts non-negative
            if (dx_reg[DELTA_W-1]) begin
                cx_reg[0] <= -dx_w;
                cy_reg[0] <= -dy_w;
                cz_reg[0] <= HALF_TURN;
            end else begin
                cx_reg[0] <= dx_w;
                cy_reg[0] <= dy_w;
                cz_reg[0] <= '0;
            end
        end
    end

    // ---------------- CORDIC iterations, one per stage ----------------
    for (genvar k = 0; k < N; k++) begin : g_cordic
        logic signed [CW-1:0] ysh, xsh;
        assign ysh = cy_reg[k] >>> k;   // floor shift
        assign xsh = cx_reg[k] >>> k;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                zero_reg[k+1] <= zero_reg[k];
                // y == 0 takes the clockwise branch
                if (!cy_reg[k][CW-1]) begin
                    cx_reg[k+1] <= cx_reg[k] + ysh;
                    cy_reg[k+1] <= cy_reg[k] - xsh;
                    cz_reg[k+1] <= cz_reg[k] + ATAN_TURNS[k];
                end else begin
                    cx_reg[k+1] <= cx_reg[k] - ysh;
                    cy_reg[k+1] <= cy_reg[k] + xsh;
                    cz_reg[k+1] <= cz_reg[k] - ATAN_TURNS[k];
                end
            end
        end

        if (k == 0) begin : g_circle
            logic [SQ_W:0] dist_sq;
            assign dist_sq = {1'b0, sqx_reg} + {1'b0, sqy_reg};
            always_ff @(posedge aclk) begin
                if (en) begin
                    ins_reg[1] <= (dist_sq <= {{(SQ_W+1-RSQ_W){1'b0}}, rsq_reg});
                end
            end
        end else begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    ins_reg[k+1] <= ins_reg[k];
                end
            end
        end
    end

    // ---------------- rounding to ANGLE_BITS ----------------
    logic                  rd_vld_reg, rd_ins_reg, rd_act_reg;
    logic [ANGLE_BITS-1:0] ang_reg;
    logic [Z_W-1:0]        z_rnd;

    // a full turn after rounding wraps to 0 through the 32-bit sum
    assign z_rnd = cz_reg[N] + (Z_W'(1) << (Z_W - 1 - ANGLE_BITS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else if (en) begin
            rd_vld_reg <= vld_reg[N];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ang_reg    <= zero_reg[N] ? '0 : z_rnd[Z_W-1 -: ANGLE_BITS];
            rd_ins_reg <= ins_reg[N];
            rd_act_reg <= ins_reg[N] && (sc_reg != '0);
        end
    end

    // ---------------- sector multiply ----------------
    logic                       mu_vld_reg, mu_ins_reg, mu_act_reg;
    logic [ANGLE_BITS+SC_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mu_vld_reg <= 1'b0;
        end else if (en) begin
            mu_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg   <= ang_reg * sc_reg;
            mu_ins_reg <= rd_ins_reg;
            mu_act_reg <= rd_act_reg;
        end
    end

    // sector = floor(angle * count / 2^ANGLE_BITS) + 1, clamped to count
    logic [SC_W:0]   sec_raw;
    logic [SC_W-1:0] sec_w;
    logic [SC_W:0]   res_w;     // {inside_res, sector}
    logic            new_vld;

    assign sec_raw = {1'b0, prod_reg[ANGLE_BITS +: SC_W]} + (SC_W+1)'(1);
    always_comb begin
        if (!mu_act_reg) begin
            sec_w = '0;
        end else if (sec_raw > {1'b0, sc_reg}) begin
            sec_w = sc_reg;
        end else begin
            sec_w = sec_raw[SC_W-1:0];
        end
    end
    assign res_w   = {mu_ins_reg, sec_w};
    assign new_vld = en && mu_vld_reg;

    // ---------------- output register and skid buffer ----------------
    logic          out_vld_reg;
    logic [SC_W:0] out_reg, skid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!out_vld_reg || m_tready) begin
            if (skid_vld_reg) begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                out_vld_reg <= new_vld;
            end
        end else if (new_vld) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_vld_reg || m_tready) begin
            out_reg <= skid_vld_reg ? skid_reg : res_w;
        end else if (new_vld) begin
            skid_reg <= res_w;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(16-SC_W-1){1'b0}}, out_reg};

    // ---------------- assertions ----------------
    `PSHT_ASSERT_IMP(a_skid_behind_out, skid_vld_reg, out_vld_reg,
        "skid buffer holds a result while the output register is empty")
    `PSHT_ASSERT_NXT(a_skid_catches, out_vld_reg && !m_tready && new_vld, skid_vld_reg,
        "result leaving the pipeline was not caught by the skid buffer")
    `PSHT_ASSERT_IMP(a_sector_needs_hit, out_vld_reg && (out_reg[SC_W-1:0] != '0),
        out_reg[SC_W], "nonzero sector reported for a point outside the circle")
    `PSHT_ASSERT_IMP(a_cordic_x_positive, vld_reg[N], !cx_reg[N][CW-1],
        "CORDIC x went negative")

endmodule
